/* rtl/core/tsb_pkg.sv */
// shared types and constants of the bilinear texture sampler
`default_nettype none

package tsb_pkg;

	// fixed field widths
	localparam int CHANNEL_BITS    = 16;
	localparam int COORD_FRAC_BITS = 16;
	localparam int COORD_BITS      = COORD_FRAC_BITS + 2;
	localparam int XY_BITS         = 16;
	localparam int DIM_REG_BITS    = 9;
	localparam int OPCODE_BITS     = 2;
	localparam int CFG_INDEX_BITS  = 1;

	// default store size per axis
	localparam int MAX_DIM_DEF = 256;

	// fixed point weight constants
	localparam int WEIGHT_BITS = COORD_FRAC_BITS + 1;
	localparam int HALF_FX     = 1 << (COORD_FRAC_BITS - 1);
	localparam int ONE_FX      = 1 << COORD_FRAC_BITS;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_WRITE,
		OP_FETCH,
		OP_NEAREST,
		OP_BILINEAR
	} opcode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TEX_WIDTH,
		REG_TEX_HEIGHT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_AXIS,
		ST_ISSUE,
		ST_WAIT1,
		ST_WAIT2,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
	} texel_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/tsb_if.sv */
// request, response and configuration channels of the texture sampler
`default_nettype none

interface tsb_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [tsb_pkg::OPCODE_BITS-1:0]         opcode;
	logic signed [tsb_pkg::XY_BITS-1:0]      x_coord;
	logic signed [tsb_pkg::XY_BITS-1:0]      y_coord;
	logic [tsb_pkg::COORD_BITS-1:0]          u_coord;
	logic [tsb_pkg::COORD_BITS-1:0]          v_coord;
	logic [tsb_pkg::CHANNEL_BITS-1:0]        red_in;
	logic [tsb_pkg::CHANNEL_BITS-1:0]        green_in;
	logic [tsb_pkg::CHANNEL_BITS-1:0]        blue_in;

	modport source (output valid, opcode, x_coord, y_coord, u_coord, v_coord,
		red_in, green_in, blue_in, input ready);
	modport sink (input valid, opcode, x_coord, y_coord, u_coord, v_coord,
		red_in, green_in, blue_in, output ready);
endinterface

interface tsb_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [tsb_pkg::CHANNEL_BITS-1:0] red_out;
	logic [tsb_pkg::CHANNEL_BITS-1:0] green_out;
	logic [tsb_pkg::CHANNEL_BITS-1:0] blue_out;
	logic                             status;

	modport source (output valid, red_out, green_out, blue_out, status, input ready);
	modport sink (input valid, red_out, green_out, blue_out, status, output ready);
endinterface

interface tsb_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [tsb_pkg::CFG_INDEX_BITS-1:0] index;
	logic [tsb_pkg::DIM_REG_BITS-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/tsb_store.sv */
// single-port texel memory with registered read data
`default_nettype none

module tsb_store #(
	parameter int DEPTH  = tsb_pkg::MAX_DIM_DEF * tsb_pkg::MAX_DIM_DEF,
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  tsb_pkg::mem_cmd_t cmd,
	input  logic [ADDR_W-1:0] addr,
	input  tsb_pkg::texel_t   wdata,
	output tsb_pkg::texel_t   rdata
);

	tsb_pkg::texel_t mem [DEPTH];
	tsb_pkg::texel_t rdata_q;

	// one access per cycle, read data registered
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/tsb_axis.sv */
// per-axis coordinate unit: scaled coordinate, corner indices and weight
`default_nettype none

module tsb_axis #(
	parameter int MAX_DIM = tsb_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                load,
	input  tsb_pkg::opcode_t                    op,
	input  logic [tsb_pkg::COORD_BITS-1:0]      coord,
	input  logic signed [tsb_pkg::XY_BITS-1:0]  pos,
	input  logic [$clog2(MAX_DIM+1)-1:0]        dim,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] lo,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] hi,
	output logic [tsb_pkg::WEIGHT_BITS-1:0]     weight,
	output logic                                oob
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int F     = tsb_pkg::COORD_FRAC_BITS;
	localparam int PW    = tsb_pkg::COORD_BITS + DIM_W;
	localparam int NW    = PW + 1 - F;
	localparam int XW    = tsb_pkg::XY_BITS;
	localparam int WB    = tsb_pkg::WEIGHT_BITS;

	logic [PW-1:0]    prod_q;
	logic [DIM_W-1:0] dim_m1;
	logic [PW:0]      near_sum;
	logic [NW-1:0]    near_i;
	logic [IDX_W-1:0] near_idx;
	logic             below;
	logic [PW-1:0]    s_val;
	logic [NW-2:0]    i0;
	logic [IDX_W-1:0] lo_b;
	logic [PW-1:0]    w_raw;
	logic [WB-1:0]    w_b;
	logic             pos_neg;
	logic             pos_big;
	logic [IDX_W-1:0] clamp_idx;
	logic [DIM_W:0]   lo_plus;

	// coordinate times texture size
	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PW'(coord) * PW'(dim);
		end
	end

	assign dim_m1 = dim - DIM_W'(1);

	// nearest: round half up, clamp to the last texel
	assign near_sum = {1'b0, prod_q} + (PW+1)'(tsb_pkg::HALF_FX);
	assign near_i   = near_sum[PW:F];
	assign near_idx = (near_i >= NW'(dim)) ? IDX_W'(dim_m1) : IDX_W'(near_i);

	// bilinear: shift back half a texel, clamp the corner, keep the fraction
	assign below = prod_q < PW'(tsb_pkg::HALF_FX);
	assign s_val = prod_q - PW'(tsb_pkg::HALF_FX);
	assign i0    = s_val[PW-1:F];
	assign lo_b  = (i0 > (NW-1)'(dim_m1)) ? IDX_W'(dim_m1) : IDX_W'(i0);
	assign w_raw = s_val - (PW'(lo_b) << F);
	assign w_b   = (w_raw > PW'(tsb_pkg::ONE_FX)) ? WB'(tsb_pkg::ONE_FX) : WB'(w_raw);

	// integer coordinate against the texture edge
	assign pos_neg   = pos[XW-1];
	assign pos_big   = !pos_neg && (XW'(pos) >= XW'(dim));
	assign clamp_idx = pos_neg ? '0 : (pos_big ? IDX_W'(dim_m1) : IDX_W'(pos));

	// per-opcode corner selection
	always_comb begin
		lo     = '0;
		weight = '0;
		oob    = 1'b0;
		unique case (op)
			tsb_pkg::OP_WRITE: begin
				lo  = IDX_W'(pos);
				oob = pos_neg || pos_big;
			end
			tsb_pkg::OP_FETCH: begin
				lo = clamp_idx;
			end
			tsb_pkg::OP_NEAREST: begin
				lo = near_idx;
			end
			tsb_pkg::OP_BILINEAR: begin
				if (!below) begin
					lo     = lo_b;
					weight = w_b;
				end
			end
			default: begin
				lo = '0;
			end
		endcase
	end

	// upper corner stays on the last texel
	assign lo_plus = (DIM_W+1)'(lo) + (DIM_W+1)'(1);
	assign hi = (lo_plus < (DIM_W+1)'(dim)) ? IDX_W'(lo_plus) : IDX_W'(dim_m1);

endmodule

`default_nettype wire

/* rtl/core/tsb_blend.sv */
// three-channel linear blend with round half up
`default_nettype none

module tsb_blend (
	input  tsb_pkg::texel_t                  a,
	input  tsb_pkg::texel_t                  b,
	input  logic [tsb_pkg::WEIGHT_BITS-1:0]  w,
	output tsb_pkg::texel_t                  y
);

	localparam int CB = tsb_pkg::CHANNEL_BITS;
	localparam int F  = tsb_pkg::COORD_FRAC_BITS;
	localparam int PW = CB + 1 + tsb_pkg::WEIGHT_BITS + 1;

	logic [2:0][CB-1:0] a_arr;
	logic [2:0][CB-1:0] b_arr;
	logic [2:0][CB-1:0] y_arr;

	assign a_arr = a;
	assign b_arr = b;
	assign y     = y_arr;

	// a + round((b - a) * w), same as a*(1-w) + b*w rounded
	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic signed [PW-1:0] a_x;
		logic signed [PW-1:0] b_x;
		logic signed [PW-1:0] w_x;
		logic signed [PW-1:0] diff;
		logic signed [PW-1:0] prod;
		logic signed [PW-1:0] rnd;
		logic signed [PW-1:0] res;

		assign a_x  = PW'(a_arr[c]);
		assign b_x  = PW'(b_arr[c]);
		assign w_x  = PW'(w);
		assign diff = b_x - a_x;
		assign prod = diff * w_x;
		assign rnd  = (prod + PW'(tsb_pkg::HALF_FX)) >>> F;
		assign res  = a_x + rnd;
		assign y_arr[c] = res[CB-1:0];
	end

endmodule

`default_nettype wire

/* rtl/core/texture_sampler_bilinear.sv */
// bilinear texture sampler top level: sequencer, configuration and result register
//
// The sampler holds a texture of up to MAX_DIM by MAX_DIM RGB texels in one
// single-port memory, texel (x, y) at y*width + x. Each request gives one
// response. A bilinear sample scales the coordinates, finds the corners and
// weights, issues the four corner reads to the single memory port, covers the
// memory latency while the second row blend forms, and forms the final blend
// into the response register before the next request is accepted. Writes,
// clamped fetches and nearest samples use one memory access. The response
// register lets a new request enter while the previous response still
// waits. Texture width and height reset to 1. The user must write them
// only while the sampler has no request in flight; the block itself does
// not enforce this. Values of 0 act as 1 and values above MAX_DIM act as
// MAX_DIM. Memory contents are undefined after reset and a texel must be
// written before it is read.
`default_nettype none

module texture_sampler_bilinear #(
	parameter int MAX_DIM = tsb_pkg::MAX_DIM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tsb_req_if.sink    req,
	tsb_rsp_if.source  rsp,
	tsb_cfg_if.sink    cfg
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MUL_W  = IDX_W + DIM_W;
	localparam int RW     = tsb_pkg::DIM_REG_BITS;
	localparam int WB     = tsb_pkg::WEIGHT_BITS;

	tsb_pkg::state_t state_q, state_next;

	logic [RW-1:0]    width_q, height_q;
	logic [DIM_W-1:0] w_eff, h_eff;

	tsb_pkg::opcode_t                     op_q;
	logic signed [tsb_pkg::XY_BITS-1:0]   x_q, y_q;
	logic [tsb_pkg::COORD_BITS-1:0]       u_q, v_q;
	tsb_pkg::texel_t                      wdata_q;

	logic [IDX_W-1:0] ax_lo, ax_hi, ay_lo, ay_hi;
	logic [WB-1:0]    ax_w, ay_w;
	logic             ax_oob, ay_oob;
	logic [IDX_W-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [WB-1:0]    du_q, dv_q;
	logic             oob_q;

	logic             prod_load, axis_load, issue, last_issue, finish;
	logic [1:0]       k_q;
	logic [IDX_W-1:0] xsel, ysel;
	logic [MUL_W-1:0] row_base;
	tsb_pkg::mem_cmd_t cmd_next, cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [1:0]        tag_s1, tag_s2;
	logic              rd_s2;
	tsb_pkg::texel_t   rdata;

	tsb_pkg::texel_t first_q, a0_q, a1_q;
	tsb_pkg::texel_t blend_a, blend_b, blend_y;
	logic [WB-1:0]   blend_w;

	logic            out_valid_q;
	tsb_pkg::texel_t out_texel_q;
	logic            status_q;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RW'(1);
			height_q <= RW'(1);
		end else if (cfg.valid && cfg.ready) begin
			unique case (tsb_pkg::cfg_reg_t'(cfg.index))
				tsb_pkg::REG_TEX_WIDTH:  width_q  <= cfg.data;
				tsb_pkg::REG_TEX_HEIGHT: height_q <= cfg.data;
				default:                 width_q  <= width_q;
			endcase
		end
	end

	// effective size: zero acts as one, oversize clamps to the store
	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (32'(width_q) > 32'(MAX_DIM)) begin
			w_eff = DIM_W'(MAX_DIM);
		end else begin
			w_eff = DIM_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (32'(height_q) > 32'(MAX_DIM)) begin
			h_eff = DIM_W'(MAX_DIM);
		end else begin
			h_eff = DIM_W'(height_q);
		end
	end

	// request capture
	assign req.ready = (state_q == tsb_pkg::ST_IDLE);

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q          <= tsb_pkg::opcode_t'(req.opcode);
			x_q           <= req.x_coord;
			y_q           <= req.y_coord;
			u_q           <= req.u_coord;
			v_q           <= req.v_coord;
			wdata_q.red   <= req.red_in;
			wdata_q.green <= req.green_in;
			wdata_q.blue  <= req.blue_in;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsb_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign last_issue = (op_q != tsb_pkg::OP_BILINEAR) || (&k_q);

	always_comb begin
		state_next = state_q;
		prod_load  = 1'b0;
		axis_load  = 1'b0;
		issue      = 1'b0;
		finish     = 1'b0;
		unique case (state_q)
			tsb_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_next = tsb_pkg::ST_PROD;
				end
			end
			tsb_pkg::ST_PROD: begin
				prod_load  = 1'b1;
				state_next = tsb_pkg::ST_AXIS;
			end
			tsb_pkg::ST_AXIS: begin
				axis_load  = 1'b1;
				state_next = tsb_pkg::ST_ISSUE;
			end
			tsb_pkg::ST_ISSUE: begin
				issue = 1'b1;
				if (last_issue) begin
					state_next = tsb_pkg::ST_WAIT1;
				end
			end
			tsb_pkg::ST_WAIT1: begin
				state_next = tsb_pkg::ST_WAIT2;
			end
			tsb_pkg::ST_WAIT2: begin
				state_next = tsb_pkg::ST_FINISH;
			end
			tsb_pkg::ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					finish     = 1'b1;
					state_next = tsb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = tsb_pkg::ST_IDLE;
			end
		endcase
	end

	// coordinate units for both axes
	tsb_axis #(.MAX_DIM(MAX_DIM)) u_axis_x (
		.clk    (clk),
		.load   (prod_load),
		.op     (op_q),
		.coord  (u_q),
		.pos    (x_q),
		.dim    (w_eff),
		.lo     (ax_lo),
		.hi     (ax_hi),
		.weight (ax_w),
		.oob    (ax_oob)
	);

	tsb_axis #(.MAX_DIM(MAX_DIM)) u_axis_y (
		.clk    (clk),
		.load   (prod_load),
		.op     (op_q),
		.coord  (v_q),
		.pos    (y_q),
		.dim    (h_eff),
		.lo     (ay_lo),
		.hi     (ay_hi),
		.weight (ay_w),
		.oob    (ay_oob)
	);

	always_ff @(posedge clk) begin
		if (axis_load) begin
			x0_q  <= ax_lo;
			x1_q  <= ax_hi;
			du_q  <= ax_w;
			y0_q  <= ay_lo;
			y1_q  <= ay_hi;
			dv_q  <= ay_w;
			oob_q <= ax_oob || ay_oob;
		end
	end

	// corner counter: bit 0 picks the column, bit 1 the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (issue) begin
			k_q <= last_issue ? 2'd0 : k_q + 2'd1;
		end
	end

	// flat address and memory command
	assign xsel     = k_q[0] ? x1_q : x0_q;
	assign ysel     = k_q[1] ? y1_q : y0_q;
	assign row_base = MUL_W'(ysel) * MUL_W'(w_eff);

	assign cmd_next.rd = issue && (op_q != tsb_pkg::OP_WRITE);
	assign cmd_next.wr = issue && (op_q == tsb_pkg::OP_WRITE) && !oob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			rd_s2  <= 1'b0;
		end else begin
			cmd_s1 <= cmd_next;
			rd_s2  <= cmd_s1.rd;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ADDR_W'(row_base + MUL_W'(xsel));
		tag_s1  <= k_q;
		tag_s2  <= tag_s1;
	end

	tsb_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
		.clk   (clk),
		.cmd   (cmd_s1),
		.addr  (addr_s1),
		.wdata (wdata_q),
		.rdata (rdata)
	);

	// shared blend: row blends while reading, column blend at the end
	assign blend_a = finish ? a0_q : first_q;
	assign blend_b = finish ? a1_q : rdata;
	assign blend_w = finish ? dv_q : du_q;

	tsb_blend u_blend (
		.a (blend_a),
		.b (blend_b),
		.w (blend_w),
		.y (blend_y)
	);

	// collect texels and row blends as read data returns
	always_ff @(posedge clk) begin
		if (rd_s2) begin
			unique case (tag_s2)
				2'd0: first_q <= rdata;
				2'd1: a0_q    <= blend_y;
				2'd2: first_q <= rdata;
				2'd3: a1_q    <= blend_y;
				default: first_q <= rdata;
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			unique case (op_q)
				tsb_pkg::OP_WRITE: begin
					out_texel_q <= '0;
					status_q    <= oob_q;
				end
				tsb_pkg::OP_FETCH, tsb_pkg::OP_NEAREST: begin
					out_texel_q <= first_q;
					status_q    <= 1'b0;
				end
				tsb_pkg::OP_BILINEAR: begin
					out_texel_q <= blend_y;
					status_q    <= 1'b0;
				end
				default: begin
					out_texel_q <= '0;
					status_q    <= 1'b0;
				end
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.red_out   = out_texel_q.red;
	assign rsp.green_out = out_texel_q.green;
	assign rsp.blue_out  = out_texel_q.blue;
	assign rsp.status    = status_q;

endmodule

`default_nettype wire

/* sim/tsb_tb_pkg.sv */
// request and response types plus the texel-store scoreboard for the sampler testbench
`timescale 1ns / 100ps

package tsb_tb_pkg;
	import tsb_pkg::*;

	localparam int STORE_DEPTH = MAX_DIM_DEF * MAX_DIM_DEF;

	typedef struct {
		opcode_t                   op;
		logic signed [XY_BITS-1:0] x;
		logic signed [XY_BITS-1:0] y;
		logic [COORD_BITS-1:0]     u;
		logic [COORD_BITS-1:0]     v;
		texel_t                    rgb;
	} sample_req_t;

	typedef struct {
		logic [CHANNEL_BITS-1:0] red;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] blue;
		logic                    status;
	} sample_rsp_t;

	// texel store mirror, size registers and the queue of expected responses
	class sampler_scoreboard;
		texel_t                  texels [STORE_DEPTH];
		bit                      known [STORE_DEPTH];
		logic [DIM_REG_BITS-1:0] width_reg;
		logic [DIM_REG_BITS-1:0] height_reg;
		sample_rsp_t             expected_q [$];
		int                      errors;
		int                      checked;
		int                      n_bilinear;
		int                      n_rejected;

		function new();
			width_reg = 1;
			height_reg = 1;
			errors = 0;
			checked = 0;
			n_bilinear = 0;
			n_rejected = 0;
		endfunction

		// zero acts as one, anything past the store edge as the store edge
		function int dim_of(logic [DIM_REG_BITS-1:0] r);
			if (r == 0) return 1;
			if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
			return int'(r);
		endfunction

		function int eff_width();
			return dim_of(width_reg);
		endfunction

		function int eff_height();
			return dim_of(height_reg);
		endfunction

		function bit is_known(int idx);
			return known[idx];
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void write_register(cfg_reg_t idx, logic [DIM_REG_BITS-1:0] data);
			case (idx)
				REG_TEX_WIDTH: width_reg = data;
				REG_TEX_HEIGHT: height_reg = data;
				default: ;
			endcase
		endfunction

		// round half up, then clamp to the last texel
		function int nearest_index(longint unsigned c, int dim);
			longint unsigned i;
			i = (c * longint'(dim) + HALF_FX) >> COORD_FRAC_BITS;
			if (i >= longint'(dim)) i = dim - 1;
			return int'(i);
		endfunction

		// lower corner, upper corner and upper weight for one axis
		function void axis_corners(input longint unsigned c, input int dim,
				output int lo, output int hi, output longint unsigned wt);
			longint unsigned p;
			longint unsigned s;
			longint unsigned i0;
			p = c * longint'(dim);
			if (p < HALF_FX) begin
				// half a texel left of the first center: stick to texel zero
				lo = 0;
				wt = 0;
			end else begin
				s = p - HALF_FX;
				i0 = s >> COORD_FRAC_BITS;
				if (i0 > longint'(dim - 1)) i0 = dim - 1;
				lo = int'(i0);
				wt = s - (i0 << COORD_FRAC_BITS);
				if (wt > ONE_FX) wt = ONE_FX;
			end
			hi = (lo + 1 < dim) ? lo + 1 : dim - 1;
		endfunction

		function longint unsigned mix(longint unsigned a, longint unsigned b,
				longint unsigned wt);
			return (a * (ONE_FX - wt) + b * wt + HALF_FX) >> COORD_FRAC_BITS;
		endfunction

		function texel_t blend_texel(texel_t a, texel_t b, longint unsigned wt);
			texel_t t;
			t.red   = CHANNEL_BITS'(mix(a.red, b.red, wt));
			t.green = CHANNEL_BITS'(mix(a.green, b.green, wt));
			t.blue  = CHANNEL_BITS'(mix(a.blue, b.blue, wt));
			return t;
		endfunction

		// update the store mirror and queue the response this request must give
		function void note_request(sample_req_t rq);
			int              w;
			int              h;
			int              xs;
			int              ys;
			int              u0;
			int              u1;
			int              v0;
			int              v1;
			longint unsigned du;
			longint unsigned dv;
			texel_t          t;
			sample_rsp_t     res;
			w = eff_width();
			h = eff_height();
			xs = rq.x;
			ys = rq.y;
			t = '0;
			res.status = 1'b0;
			case (rq.op)
				OP_WRITE: begin
					if (xs < 0 || ys < 0 || xs >= w || ys >= h) begin
						res.status = 1'b1;
						n_rejected++;
					end else begin
						texels[ys * w + xs] = rq.rgb;
						known[ys * w + xs] = 1'b1;
					end
				end
				OP_FETCH: begin
					xs = (xs < 0) ? 0 : (xs >= w) ? w - 1 : xs;
					ys = (ys < 0) ? 0 : (ys >= h) ? h - 1 : ys;
					t = texels[ys * w + xs];
				end
				OP_NEAREST: begin
					xs = nearest_index(rq.u, w);
					ys = nearest_index(rq.v, h);
					t = texels[ys * w + xs];
				end
				default: begin
					axis_corners(rq.u, w, u0, u1, du);
					axis_corners(rq.v, h, v0, v1, dv);
					t = blend_texel(
						blend_texel(texels[v0 * w + u0], texels[v0 * w + u1], du),
						blend_texel(texels[v1 * w + u0], texels[v1 * w + u1], du),
						dv);
					n_bilinear++;
				end
			endcase
			res.red = t.red;
			res.green = t.green;
			res.blue = t.blue;
			expected_q.push_back(res);
		endfunction

		// compare one accepted response against the oldest expectation
		function void check_response(sample_rsp_t got);
			sample_rsp_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: response with nothing outstanding: r=%h g=%h b=%h status=%b",
					$time, got.red, got.green, got.blue, got.status);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.red !== want.red) begin
				$display("%0t: red mismatch: expected %h actual %h", $time, want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$display("%0t: green mismatch: expected %h actual %h", $time, want.green,
					got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$display("%0t: blue mismatch: expected %h actual %h", $time, want.blue, got.blue);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status mismatch: expected %b actual %b", $time, want.status,
					got.status);
				errors++;
			end
		endfunction
	endclass

endpackage

/* sim/tb.sv */
// testbench top: drives the texture sampler through size phases and idling patterns
`timescale 1ns / 100ps

module tb;
	import tsb_pkg::*;
	import tsb_tb_pkg::*;

	localparam int RUN_LIMIT_NS  = 5_000_000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int N_PHASES      = 8;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic clk;
	logic arst_n;

	tsb_req_if req_ch();
	tsb_rsp_if rsp_ch();
	tsb_cfg_if cfg_ch();

	sampler_scoreboard sb;
	sample_rsp_t       got_rsp;
	int                send_idle_pct;
	int                recv_stall_pct;
	bit                hold_start;

	// size register values per phase, with zero and all-ones among them
	int         ph_width [N_PHASES] = '{4, 0, 511, 3, 257, 16, 7, 2};
	int         ph_height [N_PHASES] = '{3, 0, 2, 511, 1, 16, 5, 256};
	// random requests per phase; the texture fills add roughly 770 writes on top
	int         ph_count [N_PHASES] = '{90, 60, 90, 90, 100, 90, 90, 105};
	idle_mode_t ph_mode [N_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
		IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

	texture_sampler_bilinear u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout with %0d responses outstanding", sb.outstanding());
		$display("[texture_sampler_bilinear] ERROR");
		$finish;
	end

	// response side: random stalls plus one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// response monitor
	always @(posedge clk) begin : rsp_monitor
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got_rsp.red = rsp_ch.red_out;
			got_rsp.green = rsp_ch.green_out;
			got_rsp.blue = rsp_ch.blue_out;
			got_rsp.status = rsp_ch.status;
			sb.check_response(got_rsp);
		end
	end

	function automatic logic [CHANNEL_BITS-1:0] pick_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return CHANNEL_BITS'($urandom);
		endcase
	endfunction

	function automatic texel_t rand_texel();
		texel_t t;
		t.red = pick_channel();
		t.green = pick_channel();
		t.blue = pick_channel();
		return t;
	endfunction

	// mostly inside [0, 1], some anywhere in Q2.16, some on the edges
	function automatic logic [COORD_BITS-1:0] pick_coord();
		int pick;
		pick = $urandom_range(9);
		if (pick < 5) return COORD_BITS'($urandom_range(ONE_FX));
		if (pick < 8) return COORD_BITS'($urandom);
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return COORD_BITS'(ONE_FX);
			3: return COORD_BITS'(HALF_FX);
			default: return COORD_BITS'(ONE_FX - 1);
		endcase
	endfunction

	function automatic sample_req_t make_request(opcode_t op, logic signed [XY_BITS-1:0] x,
			logic signed [XY_BITS-1:0] y, logic [COORD_BITS-1:0] u,
			logic [COORD_BITS-1:0] v, texel_t rgb);
		sample_req_t rq;
		rq.op = op;
		rq.x = x;
		rq.y = y;
		rq.u = u;
		rq.v = v;
		rq.rgb = rgb;
		return rq;
	endfunction

	// random request for a w by h texture; unused fields carry noise
	function automatic sample_req_t random_request(int w, int h);
		sample_req_t rq;
		int          pick;
		rq = make_request(OP_WRITE, XY_BITS'($urandom), XY_BITS'($urandom),
			COORD_BITS'($urandom), COORD_BITS'($urandom), rand_texel());
		pick = $urandom_range(99);
		if (pick < 30) begin
			if ($urandom_range(4) != 0) begin
				rq.x = XY_BITS'($urandom_range(w - 1));
				rq.y = XY_BITS'($urandom_range(h - 1));
			end else begin
				// just past an edge, or anywhere at all
				case ($urandom_range(3))
					0: begin
						rq.x = -1;
						rq.y = XY_BITS'($urandom_range(h - 1));
					end
					1: begin
						rq.x = XY_BITS'(w);
						rq.y = XY_BITS'($urandom_range(h - 1));
					end
					2: begin
						rq.x = XY_BITS'($urandom_range(w - 1));
						rq.y = XY_BITS'(h);
					end
					default: ;
				endcase
			end
		end else if (pick < 45) begin
			rq.op = OP_FETCH;
			if ($urandom_range(1) == 0) begin
				rq.x = XY_BITS'($urandom_range(w - 1));
				rq.y = XY_BITS'($urandom_range(h - 1));
			end
		end else begin
			rq.op = (pick < 70) ? OP_NEAREST : OP_BILINEAR;
			rq.u = pick_coord();
			rq.v = pick_coord();
		end
		return rq;
	endfunction

	// offer one request after random idle cycles, hold it until accepted
	task automatic send_request(sample_req_t rq);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.opcode = rq.op;
		req_ch.x_coord = rq.x;
		req_ch.y_coord = rq.y;
		req_ch.u_coord = rq.u;
		req_ch.v_coord = rq.v;
		req_ch.red_in = rq.rgb.red;
		req_ch.green_in = rq.rgb.green;
		req_ch.blue_in = rq.rgb.blue;
		req_ch.valid = 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_request(rq);
		@(negedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [DIM_REG_BITS-1:0] data);
		cfg_ch.index = idx;
		cfg_ch.data = data;
		cfg_ch.valid = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		sb.write_register(idx, data);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// stop offering, wait for every response, then let the sequencer settle
	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write every texel of the current size whose flat index holds nothing yet
	task automatic fill_texture();
		int w;
		int h;
		int x;
		int y;
		w = sb.eff_width();
		h = sb.eff_height();
		for (y = 0; y < h; y++)
			for (x = 0; x < w; x++)
				if (!sb.is_known(y * w + x))
					send_request(make_request(OP_WRITE, XY_BITS'(x), XY_BITS'(y),
						COORD_BITS'($urandom), COORD_BITS'($urandom), rand_texel()));
	endtask

	initial begin : stimulus
		int p;
		int n;
		sb = new();
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_start = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_WRITE;
		req_ch.x_coord = '0;
		req_ch.y_coord = '0;
		req_ch.u_coord = '0;
		req_ch.v_coord = '0;
		req_ch.red_in = '0;
		req_ch.green_in = '0;
		req_ch.blue_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TEX_WIDTH;
		cfg_ch.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset size 1x1: the single texel, rejected writes, clamping at the extremes
		send_request(make_request(OP_WRITE, 16'sd0, 16'sd0, 18'h3FFFF, 18'h0,
			'{16'hFFFF, 16'h0000, 16'h8001}));
		send_request(make_request(OP_WRITE, 16'sd1, 16'sd0, 18'h0, 18'h0, rand_texel()));
		send_request(make_request(OP_WRITE, 16'sh8000, 16'sh7FFF, 18'h0, 18'h0, rand_texel()));
		send_request(make_request(OP_FETCH, 16'sh7FFF, 16'sh8000, 18'h0, 18'h0, rand_texel()));
		send_request(make_request(OP_NEAREST, 16'sd0, 16'sd0, 18'h3FFFF, 18'h0, rand_texel()));
		send_request(make_request(OP_BILINEAR, 16'sd0, 16'sd0, 18'h0, 18'h3FFFF, rand_texel()));

		for (p = 0; p < N_PHASES; p++) begin
			wait_drained();
			case (ph_mode[p])
				IDLE_NONE: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				IDLE_SENDER: begin
					send_idle_pct = 80;
					recv_stall_pct = 0;
				end
				IDLE_RECEIVER: begin
					send_idle_pct = 0;
					recv_stall_pct = 80;
				end
				default: begin
					send_idle_pct = 32;
					recv_stall_pct = 32;
				end
			endcase
			write_register(REG_TEX_WIDTH, DIM_REG_BITS'(ph_width[p]));
			write_register(REG_TEX_HEIGHT, DIM_REG_BITS'(ph_height[p]));
			fill_texture();

			if (p == 0) begin
				// 4x3: low and high edge weights, an interior blend, half-up rounding
				send_request(make_request(OP_BILINEAR, 16'sd0, 16'sd0, 18'h0, 18'h0,
					rand_texel()));
				send_request(make_request(OP_BILINEAR, 16'sd0, 16'sd0, 18'h3FFFF, 18'h3FFFF,
					rand_texel()));
				send_request(make_request(OP_BILINEAR, 16'sd0, 16'sd0, 18'h07000, 18'h09000,
					rand_texel()));
				send_request(make_request(OP_NEAREST, 16'sd0, 16'sd0, 18'h02000, 18'h02AAB,
					rand_texel()));
				send_request(make_request(OP_NEAREST, 16'sd0, 16'sd0, 18'h01FFF, 18'h10000,
					rand_texel()));
				send_request(make_request(OP_FETCH, -16'sd1, 16'sd3, 18'h0, 18'h0,
					rand_texel()));
				send_request(make_request(OP_WRITE, 16'sd3, 16'sd2, 18'h0, 18'h0,
					'{16'h0000, 16'hFFFF, 16'h00FF}));
				send_request(make_request(OP_WRITE, 16'sd4, 16'sd0, 18'h0, 18'h0, rand_texel()));
				send_request(make_request(OP_WRITE, 16'sd0, 16'sd3, 18'h0, 18'h0, rand_texel()));
				send_request(make_request(OP_WRITE, 16'sd0, -16'sd1, 18'h0, 18'h0, rand_texel()));
				send_request(make_request(OP_FETCH, 16'sd3, 16'sd2, 18'h0, 18'h0, rand_texel()));
				send_request(make_request(OP_BILINEAR, 16'sd0, 16'sd0, 18'h3FFFF, 18'h3FFFF,
					rand_texel()));
			end

			// long response hold-off while requests keep coming
			if (p == 2) hold_start = 1'b1;

			for (n = 0; n < ph_count[p]; n++) begin
				// halfway through one phase, stop and let every response come back
				if (p == 4 && n == ph_count[p] / 2) begin
					req_ch.valid = 1'b0;
					while (sb.outstanding() != 0) @(negedge clk);
				end
				send_request(random_request(sb.eff_width(), sb.eff_height()));
			end
		end
		wait_drained();

		$display("run covered %0d responses, %0d bilinear samples, %0d rejected writes",
			sb.checked, sb.n_bilinear, sb.n_rejected);
		$display("texture sizes from 1x1 up to 256 per side, under four stall patterns");
		if (sb.errors == 0) begin
			$display("[texture_sampler_bilinear] OK");
		end else begin
			$display("[texture_sampler_bilinear] ERROR");
		end
		$finish;
	end

endmodule
